/* rtl/rvaa_pkg.sv */
// Shared constants, widths and types for the axis rotation pipeline.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rvaa_pkg;

   localparam int COMPONENT_WIDTH = 18;
   localparam int ANGLE_WIDTH     = 16;
   localparam int AXIS_WIDTH      = 16;
   localparam int FRAC_BITS       = 14;
   localparam int ROUND_HALF      = 1 << (FRAC_BITS - 1);

   // quarter-wave sine, unsigned Q30
   localparam int Q_FRAC      = 30;
   localparam int Q_WIDTH     = 31;
   localparam int Q_TO_P      = Q_FRAC - FRAC_BITS;
   localparam int P_WIDTH     = FRAC_BITS + 1;
   localparam int SC_WIDTH    = FRAC_BITS + 2;
   localparam int HORNER_LAST = 5;
   localparam logic [Q_WIDTH-1:0] Q_ONE   = Q_WIDTH'(1) << Q_FRAC;
   localparam logic [Q_WIDTH:0]   Q_ROUND = (Q_WIDTH + 1)'(1) << (Q_TO_P - 1);
   localparam logic [Q_WIDTH-Q_TO_P:0] P_MAX = (Q_WIDTH - Q_TO_P + 1)'(1) << FRAC_BITS;
   localparam logic [Q_WIDTH-1:0] SIN_COEF [HORNER_LAST+1] = '{
      31'd1686629713, 31'd693598668, 31'd85569306, 31'd5026995, 31'd172272, 31'd3864
   };

   // vector datapath widths
   localparam int PROD_WIDTH = AXIS_WIDTH + COMPONENT_WIDTH;
   localparam int DOT_WIDTH  = PROD_WIDTH + 2;
   localparam int D_WIDTH    = DOT_WIDTH + 1 - FRAC_BITS;
   localparam int PARP_WIDTH = AXIS_WIDTH + D_WIDTH;
   localparam int PAR_WIDTH  = PARP_WIDTH + 1 - FRAC_BITS;
   localparam int CR_WIDTH   = PROD_WIDTH + 2 - FRAC_BITS;
   localparam int PERP_WIDTH = PAR_WIDTH + 1;
   localparam int M1_WIDTH   = PERP_WIDTH + SC_WIDTH;
   localparam int M2_WIDTH   = CR_WIDTH + SC_WIDTH;
   localparam int SUM_WIDTH  = M1_WIDTH + 2;
   localparam int RES_WIDTH  = SUM_WIDTH + 1 - FRAC_BITS;
   localparam longint COMP_MAX = (longint'(1) << (COMPONENT_WIDTH - 1)) - 1;
   localparam longint COMP_MIN = -COMP_MAX - 1;

   // pipeline
   localparam int STAGES     = 12;
   localparam int SINCOS_OUT = 10;

   typedef logic [STAGES:1] stage_en_type;

   typedef enum logic [1:0] {
      QUAD_0 = 2'd0,
      QUAD_1 = 2'd1,
      QUAD_2 = 2'd2,
      QUAD_3 = 2'd3
   } quad_type;

endpackage

`default_nettype wire

/* rtl/rvaa_req_if.sv */
// Request channel: angle, axis and vector with valid/ready.
// Depends on rvaa_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface rvaa_req_if import rvaa_pkg::*; ();
   logic                              valid;
   logic                              ready;
   logic        [ANGLE_WIDTH-1:0]     turn_angle;
   logic signed [AXIS_WIDTH-1:0]      axis_x;
   logic signed [AXIS_WIDTH-1:0]      axis_y;
   logic signed [AXIS_WIDTH-1:0]      axis_z;
   logic signed [COMPONENT_WIDTH-1:0] vec_x;
   logic signed [COMPONENT_WIDTH-1:0] vec_y;
   logic signed [COMPONENT_WIDTH-1:0] vec_z;

   modport source (output valid, turn_angle, axis_x, axis_y, axis_z, vec_x, vec_y, vec_z,
                   input ready);
   modport sink   (input valid, turn_angle, axis_x, axis_y, axis_z, vec_x, vec_y, vec_z,
                   output ready);
endinterface

`default_nettype wire

/* rtl/rvaa_rsp_if.sv */
// Response channel: rotated vector with valid/ready.
// Depends on rvaa_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface rvaa_rsp_if import rvaa_pkg::*; ();
   logic                              valid;
   logic                              ready;
   logic signed [COMPONENT_WIDTH-1:0] rot_x;
   logic signed [COMPONENT_WIDTH-1:0] rot_y;
   logic signed [COMPONENT_WIDTH-1:0] rot_z;

   modport source (output valid, rot_x, rot_y, rot_z, input ready);
   modport sink   (input valid, rot_x, rot_y, rot_z, output ready);
endinterface

`default_nettype wire

/* rtl/rvaa_qsine.sv */
// Pipelined quarter-wave sine, sin(pi/2 * x), x in Q30; Horner on x^2.
// Output at stage 9. Depends on rvaa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rvaa_qsine import rvaa_pkg::*; (
   input  logic                 clock,
   input  stage_en_type         en,
   input  logic [Q_WIDTH-1:0]   x,
   output logic [P_WIDTH-1:0]   p
);

   logic [Q_WIDTH-1:0]   xs_ff  [1:7];
   logic [Q_WIDTH-1:0]   x2s_ff [2:6];
   logic [Q_WIDTH-1:0]   t_ff   [3:8];
   logic [Q_WIDTH-1:0]   t_in   [3:8];
   logic [Q_WIDTH-1:0]   x2_in;
   logic [2*Q_WIDTH-1:0] sq;
   logic [2*Q_WIDTH-1:0] hp     [3:8];
   logic [Q_WIDTH:0]     rnd;
   logic [P_WIDTH-1:0]   p_ff;
   logic [P_WIDTH-1:0]   p_in;

   assign sq    = xs_ff[1] * xs_ff[1];
   assign x2_in = sq[Q_FRAC+Q_WIDTH-1:Q_FRAC];

   // Horner steps, one per stage
   assign hp[3]   = x2s_ff[2] * SIN_COEF[HORNER_LAST];
   assign t_in[3] = SIN_COEF[HORNER_LAST-1] - hp[3][Q_FRAC+Q_WIDTH-1:Q_FRAC];
   for (genvar k = 4; k <= 7; k++) begin : g_horner
      assign hp[k]   = x2s_ff[k-1] * t_ff[k-1];
      assign t_in[k] = SIN_COEF[7-k] - hp[k][Q_FRAC+Q_WIDTH-1:Q_FRAC];
   end
   assign hp[8]   = xs_ff[7] * t_ff[7];
   assign t_in[8] = hp[8][Q_FRAC+Q_WIDTH-1:Q_FRAC];

   always_comb begin
      rnd  = (Q_WIDTH + 1)'(t_ff[8]) + Q_ROUND;
      p_in = (rnd[Q_WIDTH:Q_TO_P] > P_MAX) ? P_WIDTH'(P_MAX) : P_WIDTH'(rnd[Q_WIDTH:Q_TO_P]);
   end

   always_ff @(posedge clock) begin
      if (en[1]) xs_ff[1] <= x;
      for (int k = 2; k <= 7; k++) begin
         if (en[k]) xs_ff[k] <= xs_ff[k-1];
      end
      if (en[2]) x2s_ff[2] <= x2_in;
      for (int k = 3; k <= 6; k++) begin
         if (en[k]) x2s_ff[k] <= x2s_ff[k-1];
      end
      for (int k = 3; k <= 8; k++) begin
         if (en[k]) t_ff[k] <= t_in[k];
      end
      if (en[9]) p_ff <= p_in;
   end

   assign p = p_ff;

endmodule

`default_nettype wire

/* rtl/rvaa_sincos.sv */
// Sine and cosine of a binary angle: two quarter-wave pipelines plus quadrant map.
// Result registered at stage 10. Depends on rvaa_pkg, rvaa_qsine.
`timescale 1ns / 1ps
`default_nettype none

module rvaa_sincos import rvaa_pkg::*; (
   input  logic                       clock,
   input  stage_en_type               en,
   input  logic [ANGLE_WIDTH-1:0]     angle,
   output logic signed [SC_WIDTH-1:0] sin_val,
   output logic signed [SC_WIDTH-1:0] cos_val
);

   logic [Q_WIDTH-1:0]        x;
   logic [Q_WIDTH-1:0]        xc;
   logic [P_WIDTH-1:0]        px;
   logic [P_WIDTH-1:0]        pxc;
   quad_type                  quad_ff [1:9];
   logic signed [SC_WIDTH-1:0] sp;
   logic signed [SC_WIDTH-1:0] cp;
   logic signed [SC_WIDTH-1:0] sin_ff, sin_in;
   logic signed [SC_WIDTH-1:0] cos_ff, cos_in;

   assign x  = Q_WIDTH'(angle[ANGLE_WIDTH-3:0]) << (32 - ANGLE_WIDTH);
   assign xc = Q_ONE - x;

   rvaa_qsine u_sin (.clock(clock), .en(en), .x(x),  .p(px));
   rvaa_qsine u_cos (.clock(clock), .en(en), .x(xc), .p(pxc));

   always_comb begin
      sp = signed'(SC_WIDTH'(px));
      cp = signed'(SC_WIDTH'(pxc));
      case (quad_ff[9])
         QUAD_0:  begin sin_in = sp;  cos_in = cp;  end
         QUAD_1:  begin sin_in = cp;  cos_in = -sp; end
         QUAD_2:  begin sin_in = -sp; cos_in = -cp; end
         default: begin sin_in = -cp; cos_in = sp;  end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en[1]) quad_ff[1] <= quad_type'(angle[ANGLE_WIDTH-1:ANGLE_WIDTH-2]);
      for (int k = 2; k <= 9; k++) begin
         if (en[k]) quad_ff[k] <= quad_ff[k-1];
      end
      if (en[SINCOS_OUT]) begin
         sin_ff <= sin_in;
         cos_ff <= cos_in;
      end
   end

   assign sin_val = sin_ff;
   assign cos_val = cos_ff;

endmodule

`default_nettype wire

/* rtl/rvaa_vec.sv */
// Vector datapath: dot and cross products, parallel/perpendicular split,
// final weighted sum, rounding and saturation. Depends on rvaa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rvaa_vec import rvaa_pkg::*; (
   input  logic                              clock,
   input  stage_en_type                      en,
   input  logic signed [AXIS_WIDTH-1:0]      axis_in [3],
   input  logic signed [COMPONENT_WIDTH-1:0] vec_in  [3],
   input  logic signed [SC_WIDTH-1:0]        sin_val,
   input  logic signed [SC_WIDTH-1:0]        cos_val,
   output logic signed [COMPONENT_WIDTH-1:0] rot     [3]
);

   logic signed [AXIS_WIDTH-1:0]      k1_ff [3], k2_ff [3], k3_ff [3];
   logic signed [COMPONENT_WIDTH-1:0] v1_ff [3], v2_ff [3], v3_ff [3], v4_ff [3];
   logic signed [PROD_WIDTH-1:0]      prod_ff [3][3], prod_in [3][3];
   logic signed [DOT_WIDTH:0]         dot_sum;
   logic signed [D_WIDTH-1:0]         d_ff, d_in;
   logic signed [DOT_WIDTH-1:0]       crs   [3];
   logic signed [CR_WIDTH-1:0]        cr3_ff [3], cr4_ff [3], cr_in [3];
   logic signed [PARP_WIDTH-1:0]      pk_ff [3], pk_in [3];
   logic signed [PARP_WIDTH:0]        pk_rnd [3];
   logic signed [PAR_WIDTH-1:0]       par_in [3];
   logic signed [PERP_WIDTH-1:0]      perp_in [3];
   logic signed [PERP_WIDTH-1:0]      perp_ff [5:10][3];
   logic signed [PAR_WIDTH-1:0]       par_ff  [5:10][3];
   logic signed [CR_WIDTH-1:0]        cr_ff   [5:10][3];
   logic signed [M1_WIDTH-1:0]        m1_ff [3], m1_in [3];
   logic signed [M2_WIDTH-1:0]        m2_ff [3], m2_in [3];
   logic signed [PAR_WIDTH-1:0]       par11_ff [3];
   logic signed [SUM_WIDTH-1:0]       sum [3];
   logic signed [RES_WIDTH-1:0]       res [3];
   logic signed [COMPONENT_WIDTH-1:0] rot_ff [3], rot_in [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            prod_in[i][j] = PROD_WIDTH'(k1_ff[i] * v1_ff[j]);
         end
      end
      dot_sum = (DOT_WIDTH + 1)'(prod_ff[0][0]) + (DOT_WIDTH + 1)'(prod_ff[1][1])
              + (DOT_WIDTH + 1)'(prod_ff[2][2]) + (DOT_WIDTH + 1)'(ROUND_HALF);
      d_in = D_WIDTH'(dot_sum >>> FRAC_BITS);
      crs[0] = DOT_WIDTH'(prod_ff[1][2]) - DOT_WIDTH'(prod_ff[2][1]);
      crs[1] = DOT_WIDTH'(prod_ff[2][0]) - DOT_WIDTH'(prod_ff[0][2]);
      crs[2] = DOT_WIDTH'(prod_ff[0][1]) - DOT_WIDTH'(prod_ff[1][0]);
      for (int i = 0; i < 3; i++) begin
         cr_in[i]   = CR_WIDTH'((crs[i] + DOT_WIDTH'(ROUND_HALF)) >>> FRAC_BITS);
         pk_in[i]   = PARP_WIDTH'(k3_ff[i] * d_ff);
         pk_rnd[i]  = (PARP_WIDTH + 1)'(pk_ff[i]) + (PARP_WIDTH + 1)'(ROUND_HALF);
         par_in[i]  = PAR_WIDTH'(pk_rnd[i] >>> FRAC_BITS);
         perp_in[i] = PERP_WIDTH'(v4_ff[i]) - PERP_WIDTH'(par_in[i]);
         m1_in[i]   = M1_WIDTH'(perp_ff[10][i] * cos_val);
         m2_in[i]   = M2_WIDTH'(cr_ff[10][i] * sin_val);
         sum[i]     = SUM_WIDTH'(m1_ff[i]) + SUM_WIDTH'(m2_ff[i])
                    + (SUM_WIDTH'(par11_ff[i]) <<< FRAC_BITS) + SUM_WIDTH'(ROUND_HALF);
         res[i]     = RES_WIDTH'(sum[i] >>> FRAC_BITS);
         if (res[i] > RES_WIDTH'(COMP_MAX)) begin
            rot_in[i] = COMPONENT_WIDTH'(COMP_MAX);
         end else if (res[i] < RES_WIDTH'(COMP_MIN)) begin
            rot_in[i] = COMPONENT_WIDTH'(COMP_MIN);
         end else begin
            rot_in[i] = COMPONENT_WIDTH'(res[i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         if (en[1]) begin
            k1_ff[i] <= axis_in[i];
            v1_ff[i] <= vec_in[i];
         end
         if (en[2]) begin
            k2_ff[i] <= k1_ff[i];
            v2_ff[i] <= v1_ff[i];
            for (int j = 0; j < 3; j++) prod_ff[i][j] <= prod_in[i][j];
         end
         if (en[3]) begin
            k3_ff[i]  <= k2_ff[i];
            v3_ff[i]  <= v2_ff[i];
            cr3_ff[i] <= cr_in[i];
         end
         if (en[4]) begin
            v4_ff[i]  <= v3_ff[i];
            cr4_ff[i] <= cr3_ff[i];
            pk_ff[i]  <= pk_in[i];
         end
         if (en[5]) begin
            perp_ff[5][i] <= perp_in[i];
            par_ff[5][i]  <= par_in[i];
            cr_ff[5][i]   <= cr4_ff[i];
         end
         for (int k = 6; k <= 10; k++) begin
            if (en[k]) begin
               perp_ff[k][i] <= perp_ff[k-1][i];
               par_ff[k][i]  <= par_ff[k-1][i];
               cr_ff[k][i]   <= cr_ff[k-1][i];
            end
         end
         if (en[11]) begin
            m1_ff[i]    <= m1_in[i];
            m2_ff[i]    <= m2_in[i];
            par11_ff[i] <= par_ff[10][i];
         end
         if (en[12]) rot_ff[i] <= rot_in[i];
      end
      if (en[3]) d_ff <= d_in;
   end

   assign rot = rot_ff;

endmodule

`default_nettype wire

/* rtl/rotate_vector_about_axis_top.sv */
// Top level of the axis rotation pipeline: handshake, stage valids and stall control.
// Depends on rvaa_pkg, rvaa_req_if, rvaa_rsp_if, rvaa_sincos, rvaa_vec.
//
// Rotates one Q3.14 vector per request about a Q1.14 unit axis by a binary angle
// (2^16 = one turn), by Rodrigues' formula, with saturated outputs. Fully pipelined:
// one request per cycle when not stalled by backpressure. Latency is set by the
// quarter-wave sine polynomial (seven chained multiplies, one per stage) feeding the
// final weighted sum. Each stage holds its own valid bit and stalls only when it and
// every stage after it are full, so empty slots close up under backpressure.
`timescale 1ns / 1ps
`default_nettype none

module rotate_vector_about_axis_top import rvaa_pkg::*; (
   input logic              clock,
   input logic              reset,
   rvaa_req_if.sink         req_chan,
   rvaa_rsp_if.source       rsp_chan
);

   logic [STAGES:1]                   vld_ff, vld_in;
   stage_en_type                      en;
   logic signed [AXIS_WIDTH-1:0]      axis_in [3];
   logic signed [COMPONENT_WIDTH-1:0] vec_in  [3];
   logic signed [COMPONENT_WIDTH-1:0] rot     [3];
   logic signed [SC_WIDTH-1:0]        sin_val, cos_val;
   logic                              req_acc, rsp_acc;

   always_comb begin
      en[STAGES] = !vld_ff[STAGES] || rsp_chan.ready;
      for (int k = STAGES - 1; k >= 1; k--) begin
         en[k] = !vld_ff[k] || en[k+1];
      end
      vld_in[1] = en[1] ? req_chan.valid : vld_ff[1];
      for (int k = 2; k <= STAGES; k++) begin
         vld_in[k] = en[k] ? vld_ff[k-1] : vld_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign axis_in = '{req_chan.axis_x, req_chan.axis_y, req_chan.axis_z};
   assign vec_in  = '{req_chan.vec_x, req_chan.vec_y, req_chan.vec_z};

   rvaa_sincos u_sincos (
      .clock   (clock),
      .en      (en),
      .angle   (req_chan.turn_angle),
      .sin_val (sin_val),
      .cos_val (cos_val)
   );

   rvaa_vec u_vec (
      .clock   (clock),
      .en      (en),
      .axis_in (axis_in),
      .vec_in  (vec_in),
      .sin_val (sin_val),
      .cos_val (cos_val),
      .rot     (rot)
   );

   assign req_chan.ready = en[1] && !reset;
   assign rsp_chan.valid = vld_ff[STAGES];
   assign rsp_chan.rot_x = rot[0];
   assign rsp_chan.rot_y = rot[1];
   assign rsp_chan.rot_z = rot[2];

   assign req_acc = req_chan.valid && en[1];
   assign rsp_acc = vld_ff[STAGES] && rsp_chan.ready;

   a_full_when_blocked: assert property (@(posedge clock) disable iff (reset)
      !en[1] |-> (&vld_ff))
      else $error("request blocked while a stage is empty");

   a_count_up: assert property (@(posedge clock) disable iff (reset)
      (req_acc && !rsp_acc) |=> ($countones(vld_ff) == $past($countones(vld_ff)) + 1))
      else $error("request lost or duplicated on entry");

   a_count_down: assert property (@(posedge clock) disable iff (reset)
      (!req_acc && rsp_acc) |=> ($countones(vld_ff) + 1 == $past($countones(vld_ff))))
      else $error("request lost or duplicated on exit");

   a_count_hold: assert property (@(posedge clock) disable iff (reset)
      (req_acc == rsp_acc) |=> ($countones(vld_ff) == $past($countones(vld_ff))))
      else $error("in-flight count changed without handshake");

endmodule

`default_nettype wire
